### src/lspm_pkg.sv
// Package for the link search and power manager: payload types, codes and constants.
`timescale 1ns / 1ps
package lspm_pkg;

  localparam int DefChannelCount = 13;
  localparam int DefPositionBits = 32;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [31:0] RenderPeriodMs = 32'd66;
  localparam logic [31:0] GiantHoldMs    = 32'd1000;
  localparam logic [7:0]  MinNapMs       = 8'd10;

  localparam logic [15:0] HopIntervalRst   = 16'd150;
  localparam logic [15:0] DataTimeoutRst   = 16'd3000;
  localparam logic [31:0] ScreenTimeoutRst = 32'd120000;
  localparam logic [31:0] DeepSleepRst     = 32'd300000;
  localparam logic [15:0] StealthRst       = 16'd5000;
  localparam logic [19:0] IdleMoveRst      = 20'd50;
  localparam logic [19:0] UiMoveRst        = 20'd500;
  localparam logic [7:0]  NapWindowRst     = 8'd85;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_PACKET = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOP_INTERVAL  = 8'd0,
    CFG_DATA_TIMEOUT  = 8'd1,
    CFG_SCREEN_TMO    = 8'd2,
    CFG_DEEP_SLEEP    = 8'd3,
    CFG_STEALTH_TMO   = 8'd4,
    CFG_IDLE_MOVE     = 8'd5,
    CFG_UI_MOVE       = 8'd6,
    CFG_NAP_WINDOW    = 8'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SCR_NONE = 2'd0,
    SCR_ON   = 2'd1,
    SCR_OFF  = 2'd2
  } screen_cmd_e;

  typedef enum logic [1:0] {
    DRAW_NONE   = 2'd0,
    DRAW_SEARCH = 2'd1,
    DRAW_GIANT  = 2'd2,
    DRAW_ALL    = 2'd3
  } draw_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic               packet_ok;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               stealth_wake;
    logic [7:0]         saved_channel;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         channel;
    logic               hopping;
    logic               screen_is_on;
    logic               stealth_active;
    logic [1:0]         screen_command;
    logic               save_channel;
    logic               retune;
    logic               deep_sleep;
    logic [1:0]         draw;
    logic [1:0]         giant_axis;
    logic signed [31:0] giant_value;
    logic [7:0]         nap_ms;
  } out_item_t;

endpackage

### src/link_search_power_manager.sv
// Top level of the link search and power manager: state, decision logic and handshakes.
`timescale 1ns / 1ps
// Path: an item is first held in the input register, and its result is then loaded into
//   the output register, which drives out_valid_o, once that slot is empty or being
//   taken.
// Throughput: one item per cycle unless the output stalls; every decision is a handful
//   of parallel 32-bit subtract-and-compares plus two position differences per axis.
// Reset (rst_ni low, asynchronous): both stages empty, configuration at its defaults,
//   channel 1, searching and screen on, stealth off, positions and times zero.
module link_search_power_manager
  import lspm_pkg::*;
#(
  parameter int ChannelCount = DefChannelCount,
  parameter int PositionBits = DefPositionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Width that holds either a stored position or a 32-bit field, sign-extended.
  localparam int ExtW  = (PositionBits > 32) ? PositionBits : 32;
  // Width of a position difference, and a compare width widened so a 20-bit threshold fits.
  localparam int DiffW = PositionBits + 1;
  localparam int CmpW  = (DiffW > 21) ? DiffW : 21;

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------------
  logic [15:0] hop_interval_q, data_timeout_q, stealth_tmo_q;
  logic [31:0] screen_tmo_q, deep_sleep_q;
  logic [19:0] idle_move_q, ui_move_q;
  logic [7:0]  nap_window_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_interval_q <= HopIntervalRst;
      data_timeout_q <= DataTimeoutRst;
      screen_tmo_q   <= ScreenTimeoutRst;
      deep_sleep_q   <= DeepSleepRst;
      stealth_tmo_q  <= StealthRst;
      idle_move_q    <= IdleMoveRst;
      ui_move_q      <= UiMoveRst;
      nap_window_q   <= NapWindowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HOP_INTERVAL: hop_interval_q <= cfg_data_i[15:0];
        CFG_DATA_TIMEOUT: data_timeout_q <= cfg_data_i[15:0];
        CFG_SCREEN_TMO:   screen_tmo_q   <= cfg_data_i;
        CFG_DEEP_SLEEP:   deep_sleep_q   <= cfg_data_i;
        CFG_STEALTH_TMO:  stealth_tmo_q  <= cfg_data_i[15:0];
        CFG_IDLE_MOVE:    idle_move_q    <= cfg_data_i[19:0];
        CFG_UI_MOVE:      ui_move_q      <= cfg_data_i[19:0];
        CFG_NAP_WINDOW:   nap_window_q   <= cfg_data_i[7:0];
        default: ;        // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and output register. An item advances from the first to the
  // second when the output slot is empty or is being taken in the same cycle.
  // ---------------------------------------------------------------------------
  logic      in_valid_q, out_valid_q, advance;
  in_item_t  in_q;
  out_item_t out_q, res;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Block state.
  // ---------------------------------------------------------------------------
  logic signed [PositionBits-1:0] cur_pos_q [3], cur_pos_d [3];
  logic signed [PositionBits-1:0] ref_pos_q [3], ref_pos_d [3];
  logic signed [PositionBits-1:0] disp_pos_q [3], disp_pos_d [3];
  logic signed [PositionBits-1:0] pkt_pos [3];
  logic [31:0] last_pkt_q, last_pkt_d, last_hop_q, last_hop_d;
  logic [31:0] last_strict_q, last_strict_d, last_disp_q, last_disp_d;
  logic [31:0] last_render_q, last_render_d, sess_start_q, sess_start_d;
  logic [3:0]  chan_q, chan_d;
  logic        searching_q, searching_d, screen_q, screen_d, stealth_q, stealth_d;
  logic [1:0]  active_axis_q, active_axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        cur_pos_q[a]  <= '0;
        ref_pos_q[a]  <= '0;
        disp_pos_q[a] <= '0;
      end
      last_pkt_q    <= '0;
      last_hop_q    <= '0;
      last_strict_q <= '0;
      last_disp_q   <= '0;
      last_render_q <= '0;
      sess_start_q  <= '0;
      chan_q        <= 4'd1;
      searching_q   <= 1'b1;
      screen_q      <= 1'b1;
      stealth_q     <= 1'b0;
      active_axis_q <= AXIS_NONE;
    end else if (advance) begin
      for (int a = 0; a < 3; a++) begin
        cur_pos_q[a]  <= cur_pos_d[a];
        ref_pos_q[a]  <= ref_pos_d[a];
        disp_pos_q[a] <= disp_pos_d[a];
      end
      last_pkt_q    <= last_pkt_d;
      last_hop_q    <= last_hop_d;
      last_strict_q <= last_strict_d;
      last_disp_q   <= last_disp_d;
      last_render_q <= last_render_d;
      sess_start_q  <= sess_start_d;
      chan_q        <= chan_d;
      searching_q   <= searching_d;
      screen_q      <= screen_d;
      stealth_q     <= stealth_d;
      active_axis_q <= active_axis_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis movement tests and packet position wrap, all axes in parallel.
  // ---------------------------------------------------------------------------
  logic signed [31:0] in_pos [3];
  logic [2:0]         strict_hit, disp_hit;

  assign in_pos[0] = in_q.pos_x;
  assign in_pos[1] = in_q.pos_y;
  assign in_pos[2] = in_q.pos_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [ExtW-1:0]  in_ext;
    logic signed [DiffW-1:0] d_strict, d_disp;
    logic [DiffW-1:0]        m_strict, m_disp;

    // Wrap or sign-extend the packet field to the stored width.
    assign in_ext     = ExtW'(in_pos[a]);
    assign pkt_pos[a] = in_ext[PositionBits-1:0];

    assign d_strict = DiffW'(cur_pos_q[a]) - DiffW'(ref_pos_q[a]);
    assign d_disp   = DiffW'(cur_pos_q[a]) - DiffW'(disp_pos_q[a]);
    assign m_strict = d_strict[DiffW-1] ? DiffW'(-d_strict) : DiffW'(d_strict);
    assign m_disp   = d_disp[DiffW-1]   ? DiffW'(-d_disp)   : DiffW'(d_disp);

    assign strict_hit[a] = CmpW'(m_strict) > CmpW'(idle_move_q);
    assign disp_hit[a]   = CmpW'(m_disp)   > CmpW'(ui_move_q);
  end

  // ---------------------------------------------------------------------------
  // Elapsed times, every one against the stored stamp, wrapping mod 2^32.
  // ---------------------------------------------------------------------------
  logic [31:0] now, since_pkt, since_strict, since_hop, since_sess;
  logic [31:0] since_render, since_disp;
  logic [4:0]  chan_inc;
  logic [3:0]  start_chan;
  logic [7:0]  nap_left;
  logic [1:0]  hit_axis;
  logic        moved, link_lost, giant;

  assign now          = in_q.now_ms;
  assign since_pkt    = now - last_pkt_q;
  assign since_strict = now - last_strict_q;
  assign since_hop    = now - last_hop_q;
  assign since_sess   = now - sess_start_q;
  assign since_render = now - last_render_q;
  assign since_disp   = now - last_disp_q;
  assign nap_left     = nap_window_q - since_pkt[7:0];

  assign moved     = |strict_hit;
  assign link_lost = since_pkt > 32'(data_timeout_q);
  assign chan_inc  = {1'b0, chan_q} + 5'd1;

  // Clamp the saved channel; anything outside 1..ChannelCount restarts at 1.
  assign start_chan = (in_q.saved_channel == 8'd0 ||
                       in_q.saved_channel > 8'(ChannelCount)) ? 4'd1
                                                              : in_q.saved_channel[3:0];

  // First axis, in X, Y, Z order, that moved past the display threshold.
  always_comb begin
    hit_axis = AXIS_NONE;
    if (disp_hit[0]) begin
      hit_axis = AXIS_X;
    end else if (disp_hit[1]) begin
      hit_axis = AXIS_Y;
    end else if (disp_hit[2]) begin
      hit_axis = AXIS_Z;
    end
  end

  // A fresh hit restarts the hold window, so it always shows the giant axis.
  assign giant = (hit_axis != AXIS_NONE) ||
                 (active_axis_q != AXIS_NONE && since_disp < GiantHoldMs);

  // ---------------------------------------------------------------------------
  // Next state and result for the item in the input register.
  // ---------------------------------------------------------------------------
  logic signed [ExtW-1:0] gval_ext;

  always_comb begin
    case (active_axis_d)
      AXIS_X:  gval_ext = ExtW'(cur_pos_q[0]);
      AXIS_Y:  gval_ext = ExtW'(cur_pos_q[1]);
      AXIS_Z:  gval_ext = ExtW'(cur_pos_q[2]);
      default: gval_ext = '0;
    endcase
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cur_pos_d[a]  = cur_pos_q[a];
      ref_pos_d[a]  = ref_pos_q[a];
      disp_pos_d[a] = disp_pos_q[a];
    end
    last_pkt_d    = last_pkt_q;
    last_hop_d    = last_hop_q;
    last_strict_d = last_strict_q;
    last_disp_d   = last_disp_q;
    last_render_d = last_render_q;
    sess_start_d  = sess_start_q;
    chan_d        = chan_q;
    searching_d   = searching_q;
    screen_d      = screen_q;
    stealth_d     = stealth_q;
    active_axis_d = active_axis_q;

    res                = '0;
    res.screen_command = SCR_NONE;
    res.draw           = DRAW_NONE;
    res.giant_axis     = AXIS_NONE;

    case (in_q.operation)
      OP_START: begin
        stealth_d     = in_q.stealth_wake;
        sess_start_d  = now;
        chan_d        = start_chan;
        res.retune    = 1'b1;
        last_pkt_d    = now;
        last_strict_d = now;
        if (in_q.stealth_wake) begin
          res.screen_command = SCR_OFF;
        end
      end

      OP_PACKET: begin
        if (in_q.packet_ok) begin
          for (int a = 0; a < 3; a++) begin
            cur_pos_d[a] = pkt_pos[a];
          end
          last_pkt_d = now;
          if (stealth_q) begin
            stealth_d          = 1'b0;
            res.screen_command = SCR_ON;
          end
          if (searching_q) begin
            searching_d      = 1'b0;
            res.save_channel = 1'b1;
          end
        end
      end

      OP_TICK: begin
        if (since_pkt > deep_sleep_q) begin
          res.deep_sleep = 1'b1;
        end

        // Strict movement resets the idle clock, so a moved tick never times out.
        if (moved) begin
          for (int a = 0; a < 3; a++) begin
            ref_pos_d[a] = cur_pos_q[a];
          end
          last_strict_d = now;
          if (!screen_q) begin
            screen_d           = 1'b1;
            res.screen_command = SCR_ON;
          end
        end else if (screen_q && since_strict > screen_tmo_q) begin
          screen_d           = 1'b0;
          res.screen_command = SCR_OFF;
        end

        // Link lost: enter search, or step the channel once the hop interval ran out.
        if (link_lost) begin
          searching_d = 1'b1;
          if (!searching_q) begin
            last_hop_d = now;
          end else if (since_hop > 32'(hop_interval_q)) begin
            chan_d     = (chan_inc > 5'(ChannelCount)) ? 4'd1 : chan_inc[3:0];
            res.retune = 1'b1;
            last_hop_d = now;
          end
          if (stealth_q && since_sess > 32'(stealth_tmo_q)) begin
            res.deep_sleep = 1'b1;
          end
        end

        // Render pacing.
        if (screen_d && since_render > RenderPeriodMs) begin
          if (searching_d) begin
            res.draw = DRAW_SEARCH;
          end else begin
            if (hit_axis != AXIS_NONE) begin
              active_axis_d = hit_axis;
              last_disp_d   = now;
            end
            for (int a = 0; a < 3; a++) begin
              disp_pos_d[a] = cur_pos_q[a];
            end
            if (giant) begin
              res.draw        = DRAW_GIANT;
              res.giant_axis  = active_axis_d;
              res.giant_value = gval_ext[31:0];
            end else begin
              res.draw = DRAW_ALL;
            end
          end
          last_render_d = now;
        end

        // Light-sleep nap inside the window after the last packet.
        if (!searching_d && screen_d && since_pkt < 32'(nap_window_q) &&
            nap_left > MinNapMs) begin
          res.nap_ms = nap_left;
        end
      end

      default: ;  // hold all state, report flags only
    endcase

    res.channel        = chan_d;
    res.hopping        = searching_d;
    res.screen_is_on   = screen_d;
    res.stealth_active = stealth_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_chan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q != 4'd0 && 5'(chan_q) <= 5'(ChannelCount))
    else $error("channel left the valid range");

  a_giant_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.draw != DRAW_GIANT |->
      out_item_o.giant_axis == AXIS_NONE && out_item_o.giant_value == 32'sd0)
    else $error("giant fields set without a giant draw");

  a_nap_cond : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.nap_ms != 8'd0 |->
      !out_item_o.hopping && out_item_o.screen_is_on && out_item_o.nap_ms > MinNapMs)
    else $error("nap reported while searching, screen off or too short");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule
